/* hdl/caw_pkg.sv */
// ----------------------------------------------------------------------------
// caw_pkg: shared types and constants of the window averager
// Field widths, register reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package caw_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OUT_W      = 20;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WINDOW_DEF = 64;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [SAMPLE_W-1:0]      RST_SPLIT   = 12'd2048;
  localparam logic [GAIN_W-1:0]        RST_VGAIN   = 16'd256;
  localparam logic [GAIN_W-1:0]        RST_CGAIN   = 16'd256;
  localparam logic signed [TEMP_W-1:0] RST_TBASE   = 16'sd6400;
  localparam logic [SAMPLE_W-1:0]      RST_TREF    = 12'd1750;
  localparam logic [GAIN_W-1:0]        RST_TSLOPE  = 16'd13304;
  localparam logic [SAMPLE_W-1:0]      RST_TRIP_HI = 12'd4023;
  localparam logic [SAMPLE_W-1:0]      RST_TRIP_LO = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPLIT   = 3'd0,
    CFG_VGAIN   = 3'd1,
    CFG_CGAIN   = 3'd2,
    CFG_TBASE   = 3'd3,
    CFG_TREF    = 3'd4,
    CFG_TSLOPE  = 3'd5,
    CFG_TRIP_HI = 3'd6,
    CFG_TRIP_LO = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      split;
    logic [GAIN_W-1:0]        vgain;
    logic [GAIN_W-1:0]        cgain;
    logic signed [TEMP_W-1:0] tbase;
    logic [SAMPLE_W-1:0]      tref;
    logic [GAIN_W-1:0]        tslope;
    logic [SAMPLE_W-1:0]      trip_hi;
    logic [SAMPLE_W-1:0]      trip_lo;
  } cfg_t;

  // status of the beat on the input channel
  typedef struct packed {
    logic trip;
    logic last;
  } acc_stat_t;

  typedef struct packed {
    logic                     kind;
    logic [OUT_W-1:0]         vlow;
    logic [OUT_W-1:0]         vhigh;
    logic                     lempty;
    logic                     hempty;
    logic [OUT_W-1:0]         cur;
    logic signed [TEMP_W-1:0] temp;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LMUL,
    S_LDIV,
    S_HMUL,
    S_HDIV,
    S_CMUL,
    S_CDIV,
    S_TDIV,
    S_TMUL,
    S_OUT
  } seq_state_e;

endpackage

/* hdl/caw_accum.sv */
// ----------------------------------------------------------------------------
// caw_accum: watchdog check and window accumulators
// Sorts voltage into the two buckets, sums current and temperature and counts
// the window. Presents the sums including the current beat for the sequencer.
// ----------------------------------------------------------------------------
module caw_accum
  import caw_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW),
  parameter int unsigned CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [SAMPLE_W-1:0] voltage_i,
  input  logic [SAMPLE_W-1:0] current_i,
  input  logic [SAMPLE_W-1:0] temp_i,
  input  cfg_t                cfg_i,
  output acc_stat_t           stat_o,
  output logic [SUM_W-1:0]    low_sum_o,
  output logic [CNT_W-1:0]    low_cnt_o,
  output logic [SUM_W-1:0]    high_sum_o,
  output logic [CNT_W-1:0]    high_cnt_o,
  output logic [SUM_W-1:0]    cur_sum_o,
  output logic [SUM_W-1:0]    temp_sum_o
);

  logic [SUM_W-1:0] low_sum_q, high_sum_q, cur_sum_q, temp_sum_q;
  logic [CNT_W-1:0] low_cnt_q, high_cnt_q, win_q;
  logic             is_high;

  assign is_high     = voltage_i > cfg_i.split;
  assign stat_o.trip = (current_i > cfg_i.trip_hi) || (current_i < cfg_i.trip_lo);
  assign stat_o.last = (win_q == CNT_W'(WINDOW - 1));

  assign low_sum_o  = is_high ? low_sum_q : low_sum_q + SUM_W'(voltage_i);
  assign high_sum_o = is_high ? high_sum_q + SUM_W'(voltage_i) : high_sum_q;
  assign low_cnt_o  = low_cnt_q + CNT_W'(!is_high);
  assign high_cnt_o = high_cnt_q + CNT_W'(is_high);
  assign cur_sum_o  = cur_sum_q + SUM_W'(current_i);
  assign temp_sum_o = temp_sum_q + SUM_W'(temp_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_sum_q  <= '0;
      high_sum_q <= '0;
      cur_sum_q  <= '0;
      temp_sum_q <= '0;
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
      win_q      <= '0;
    end else if (accept_i && !stat_o.trip) begin
      if (stat_o.last) begin
        // window complete: sums move to the sequencer, start afresh
        low_sum_q  <= '0;
        high_sum_q <= '0;
        cur_sum_q  <= '0;
        temp_sum_q <= '0;
        low_cnt_q  <= '0;
        high_cnt_q <= '0;
        win_q      <= '0;
      end else begin
        low_sum_q  <= low_sum_o;
        high_sum_q <= high_sum_o;
        cur_sum_q  <= cur_sum_o;
        temp_sum_q <= temp_sum_o;
        low_cnt_q  <= low_cnt_o;
        high_cnt_q <= high_cnt_o;
        win_q      <= win_q + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_bucket_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+1)'(low_cnt_q) + (CNT_W+1)'(high_cnt_q)) == (CNT_W+1)'(win_q))
    else $error("bucket counts do not add up to the window count");

  a_trip_holds_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && stat_o.trip) |=> $stable(win_q))
    else $error("tripped beat advanced the window");
`endif

endmodule

/* hdl/caw_smul.sv */
// ----------------------------------------------------------------------------
// caw_smul: bit-serial shift-and-add multiplier
// One multiplier bit per cycle, LSB first; done pulses when the product holds.
// ----------------------------------------------------------------------------
module caw_smul
  import caw_pkg::*;
#(
  parameter int unsigned A_W = SAMPLE_W,
  parameter int unsigned B_W = GAIN_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned STP_W = $clog2(B_W);

  logic [A_W-1:0]   a_q;
  logic [P_W-1:0]   p_q;
  logic [A_W:0]     part_sum;
  logic [STP_W-1:0] step_q;
  logic             busy_q, done_q;

  // upper half accumulates, lower half shifts the multiplier out
  assign part_sum = {1'b0, p_q[P_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STP_W'(B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {part_sum, p_q[B_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

/* hdl/caw_sdiv.sv */
// ----------------------------------------------------------------------------
// caw_sdiv: restoring radix-2 divider
// One quotient bit per cycle, MSB first; done pulses when the quotient holds.
// ----------------------------------------------------------------------------
module caw_sdiv
  import caw_pkg::*;
#(
  parameter int unsigned N_W = OUT_W,
  parameter int unsigned D_W = SAMPLE_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [N_W-1:0] quo_o
);

  localparam int unsigned STP_W = $clog2(N_W);

  logic [N_W-1:0]   q_q;
  logic [D_W-1:0]   r_q, den_q;
  logic [D_W:0]     trial, rem_sub;
  logic             ge;
  logic [STP_W-1:0] step_q;
  logic             busy_q, done_q;

  assign trial   = {r_q, q_q[N_W-1]};
  assign ge      = trial >= {1'b0, den_q};
  assign rem_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STP_W'(N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q <= {q_q[N_W-2:0], ge};
      r_q <= ge ? rem_sub[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

/* hdl/charger_adc_window_averager.sv */
// ----------------------------------------------------------------------------
// charger_adc_window_averager: windowed ADC averager with current watchdog
// Channels: input beats (voltage, current, temperature sample) on
// in_valid_i/in_ready_o, result beats on out_valid_o/out_ready_i, register
// writes on cfg_valid_i/cfg_ready_o (always ready, index and 16-bit data).
// A beat whose current sample lies outside the trip limits gives a trip
// result in the next cycle and leaves the window untouched. Other beats are
// summed into the window; the next beat may follow at once.
// The WINDOW-th summed beat starts the sequencer, which runs a 16-step serial
// multiplier and a one-bit-per-cycle divider of NUM_W = 20 + log2(WINDOW)
// steps: three multiply-divide pairs for the two voltage buckets and current,
// one divide for the mean temperature and one multiply for its slope term.
// No input beat is taken while the sequencer runs, from the last beat to the result.
// Results wait in an output register; while it is full and out_ready_i is
// low, input beats are held off and a finished window waits for it.
// Reset clears the window sums and counts and loads the register defaults.
// ----------------------------------------------------------------------------
module charger_adc_window_averager
  import caw_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SAMPLE_W-1:0]       voltage_sample_i,
  input  logic [SAMPLE_W-1:0]       current_sample_i,
  input  logic [SAMPLE_W-1:0]       temperature_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [OUT_W-1:0]          voltage_low_side_o,
  output logic [OUT_W-1:0]          voltage_high_side_o,
  output logic                      low_side_empty_o,
  output logic                      high_side_empty_o,
  output logic [OUT_W-1:0]          current_value_o,
  output logic signed [TEMP_W-1:0]  temperature_value_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PROD_W = SUM_W + GAIN_W;
  localparam int unsigned NUM_W  = PROD_W - FRAC_W;
  localparam int unsigned TP_W   = SAMPLE_W + GAIN_W;
  localparam int unsigned DLT_W  = TP_W + 1 - FRAC_W;
  localparam int unsigned TW_W   = DLT_W + 1;

  function automatic logic [OUT_W-1:0] sat_out(input logic [NUM_W-1:0] q);
    logic [OUT_W-1:0] r;
    r = (q > NUM_W'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
    return r;
  endfunction

  // configuration
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.split   <= RST_SPLIT;
      cfg_q.vgain   <= RST_VGAIN;
      cfg_q.cgain   <= RST_CGAIN;
      cfg_q.tbase   <= RST_TBASE;
      cfg_q.tref    <= RST_TREF;
      cfg_q.tslope  <= RST_TSLOPE;
      cfg_q.trip_hi <= RST_TRIP_HI;
      cfg_q.trip_lo <= RST_TRIP_LO;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SPLIT:   cfg_q.split   <= cfg_data_i[SAMPLE_W-1:0];
        CFG_VGAIN:   cfg_q.vgain   <= cfg_data_i;
        CFG_CGAIN:   cfg_q.cgain   <= cfg_data_i;
        CFG_TBASE:   cfg_q.tbase   <= $signed(cfg_data_i);
        CFG_TREF:    cfg_q.tref    <= cfg_data_i[SAMPLE_W-1:0];
        CFG_TSLOPE:  cfg_q.tslope  <= cfg_data_i;
        CFG_TRIP_HI: cfg_q.trip_hi <= cfg_data_i[SAMPLE_W-1:0];
        CFG_TRIP_LO: cfg_q.trip_lo <= cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulators
  acc_stat_t        acc_stat;
  logic             in_acc, job_load;
  logic [SUM_W-1:0] snap_lsum, snap_hsum, snap_csum, snap_tsum;
  logic [CNT_W-1:0] snap_lcnt, snap_hcnt;

  caw_accum #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .voltage_i  (voltage_sample_i),
    .current_i  (current_sample_i),
    .temp_i     (temperature_sample_i),
    .cfg_i      (cfg_q),
    .stat_o     (acc_stat),
    .low_sum_o  (snap_lsum),
    .low_cnt_o  (snap_lcnt),
    .high_sum_o (snap_hsum),
    .high_cnt_o (snap_hcnt),
    .cur_sum_o  (snap_csum),
    .temp_sum_o (snap_tsum)
  );

  // serial arithmetic units
  logic              mul_start, mul_busy, mul_done;
  logic [SUM_W-1:0]  mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [CNT_W-1:0]  div_den;

  caw_smul #(
    .A_W (SUM_W),
    .B_W (GAIN_W)
  ) u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  caw_sdiv #(
    .N_W (NUM_W),
    .D_W (CNT_W)
  ) u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // window snapshot and partial results
  logic [SUM_W-1:0]        jl_sum_q, jh_sum_q, jc_sum_q, jt_sum_q;
  logic [CNT_W-1:0]        jl_cnt_q, jh_cnt_q;
  logic [OUT_W-1:0]        low_q, high_q, cur_q;
  logic                    neg_q;
  logic signed [DLT_W-1:0] delta_q;

  seq_state_e state_q, state_d;
  result_t    out_q, out_d;
  logic       out_valid_q, out_free, out_load;

  // temperature slope term: |tref - mean| times slope, sign kept aside
  logic [SAMPLE_W:0]   t_diff, t_mag;
  logic                t_neg;
  logic [TP_W:0]       t_prod, t_sprod;
  logic signed [TW_W-1:0] t_wide;
  logic signed [TEMP_W-1:0] t_val;

  assign t_diff  = {1'b0, cfg_q.tref} - {1'b0, div_quo[SAMPLE_W-1:0]};
  assign t_neg   = t_diff[SAMPLE_W];
  assign t_mag   = t_neg ? ((SAMPLE_W+1)'(0) - t_diff) : t_diff;
  assign t_prod  = {1'b0, mul_prod[TP_W-1:0]};
  assign t_sprod = neg_q ? ((TP_W+1)'(0) - t_prod) : t_prod;
  assign t_wide  = $signed({{(TW_W-TEMP_W){cfg_q.tbase[TEMP_W-1]}}, cfg_q.tbase})
                 - $signed({delta_q[DLT_W-1], delta_q});

  always_comb begin
    if (t_wide > TW_W'(32767)) begin
      t_val = 16'sh7FFF;
    end else if (t_wide < -TW_W'(32768)) begin
      t_val = 16'sh8000;
    end else begin
      t_val = t_wide[TEMP_W-1:0];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign job_load   = in_acc && !acc_stat.trip && acc_stat.last;

  // sequencer
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = jl_sum_q;
    mul_b     = cfg_q.vgain;
    div_start = 1'b0;
    div_num   = mul_prod[PROD_W-1:FRAC_W];
    div_den   = jl_cnt_q;
    out_load  = 1'b0;
    out_d     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && acc_stat.trip) begin
          out_load   = 1'b1;
          out_d.kind = 1'b1;
        end else if (job_load) begin
          state_d = S_START;
        end
      end
      S_START: begin
        mul_start = 1'b1;
        state_d   = S_LMUL;
      end
      S_LMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_LDIV;
        end
      end
      S_LDIV: begin
        mul_a = jh_sum_q;
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = S_HMUL;
        end
      end
      S_HMUL: begin
        div_den = jh_cnt_q;
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_HDIV;
        end
      end
      S_HDIV: begin
        mul_a = jc_sum_q;
        mul_b = cfg_q.cgain;
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = S_CMUL;
        end
      end
      S_CMUL: begin
        div_den = CNT_W'(WINDOW);
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_CDIV;
        end
      end
      S_CDIV: begin
        // mean temperature: plain sum over the window length
        div_num = NUM_W'(jt_sum_q);
        div_den = CNT_W'(WINDOW);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_TDIV;
        end
      end
      S_TDIV: begin
        mul_a = SUM_W'(t_mag[SAMPLE_W-1:0]);
        mul_b = cfg_q.tslope;
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = S_TMUL;
        end
      end
      S_TMUL: begin
        if (mul_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_d.kind   = 1'b0;
        out_d.vlow   = (jl_cnt_q == '0) ? '0 : low_q;
        out_d.vhigh  = (jh_cnt_q == '0) ? '0 : high_q;
        out_d.lempty = (jl_cnt_q == '0);
        out_d.hempty = (jh_cnt_q == '0);
        out_d.cur    = cur_q;
        out_d.temp   = t_val;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      jl_sum_q <= snap_lsum;
      jh_sum_q <= snap_hsum;
      jc_sum_q <= snap_csum;
      jt_sum_q <= snap_tsum;
      jl_cnt_q <= snap_lcnt;
      jh_cnt_q <= snap_hcnt;
    end
    if (state_q == S_LDIV && div_done) begin
      low_q <= sat_out(div_quo);
    end
    if (state_q == S_HDIV && div_done) begin
      high_q <= sat_out(div_quo);
    end
    if (state_q == S_CDIV && div_done) begin
      cur_q <= sat_out(div_quo);
    end
    if (state_q == S_TDIV && div_done) begin
      neg_q <= t_neg;
    end
    // drop eight fraction bits, rounding towards minus infinity
    if (state_q == S_TMUL && mul_done) begin
      delta_q <= $signed(t_sprod[TP_W:FRAC_W]);
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_q.kind;
  assign voltage_low_side_o  = out_q.vlow;
  assign voltage_high_side_o = out_q.vhigh;
  assign low_side_empty_o    = out_q.lempty;
  assign high_side_empty_o   = out_q.hempty;
  assign current_value_o     = out_q.cur;
  assign temperature_value_o = out_q.temp;

`ifndef SYNTHESIS
  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_trip_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && acc_stat.trip) |=> (out_valid_q && out_q.kind))
    else $error("tripped beat gave no trip result");
`endif

endmodule
